>>> src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants and types for the line sensor centroid pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int THR_W    = 12;
    localparam int SPREAD_W = 28;
    localparam int POS_W    = 15;
    localparam int QBITS    = 14;   // |position| <= 10880 < 2^14
    localparam int LIMIT_W  = 29;   // 30 * 4095^2 < 2^29
    localparam int THR_SQ_W = 2 * THR_W;

    localparam logic [THR_W-1:0] THR_RESET = 12'd102;

    typedef struct packed {
        logic                found;
        logic                neg;
        logic [SPREAD_W-1:0] spread;
    } lsc_side_t;

endpackage

`default_nettype wire

>>> src/lsc_div.sv
// ----------------------------------------------------------------------------
// lsc_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 15
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [DIVIDEND_W-1:0]  in_dividend,
    input  wire logic [DIVISOR_W-1:0]   in_divisor,
    input  wire lsc_pkg::lsc_side_t     in_side,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [lsc_pkg::QBITS-1:0]   out_quot,
    output lsc_pkg::lsc_side_t          out_side
);
    import lsc_pkg::*;

    logic [QBITS-1:0]      v_reg;
    logic [QBITS:0]        rdy;
    logic [DIVIDEND_W-1:0] rem_reg  [QBITS];
    logic [DIVISOR_W-1:0]  dvs_reg  [QBITS];
    logic [QBITS-1:0]      quot_reg [QBITS];
    lsc_side_t             side_reg [QBITS];

    assign rdy[QBITS] = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[QBITS-1];
    assign out_quot   = quot_reg[QBITS-1];
    assign out_side   = side_reg[QBITS-1];

    for (genvar j = 0; j < QBITS; j++) begin : g_stage
        localparam int K = QBITS - 1 - j;

        logic                  v_prev;
        logic [DIVIDEND_W-1:0] rem_prev;
        logic [DIVISOR_W-1:0]  dvs_prev;
        logic [QBITS-1:0]      quot_prev;
        lsc_side_t             side_prev;
        logic [DIVIDEND_W-1:0] trial;
        logic [DIVIDEND_W-1:0] rem_next;
        logic [QBITS-1:0]      quot_next;

        if (j == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = in_dividend;
            assign dvs_prev  = in_divisor;
            assign quot_prev = '0;
            assign side_prev = in_side;
        end
        else begin : g_next
            assign v_prev    = v_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign dvs_prev  = dvs_reg[j-1];
            assign quot_prev = quot_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        assign rdy[j] = ~v_reg[j] | rdy[j+1];

        always_comb
        begin
            trial     = DIVIDEND_W'(dvs_prev) << K;
            rem_next  = rem_prev;
            quot_next = quot_prev;
            if (rem_prev >= trial)
            begin
                rem_next     = rem_prev - trial;
                quot_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                v_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rem_reg[j]  <= rem_next;
                dvs_reg[j]  <= dvs_prev;
                quot_reg[j] <= quot_next;
                side_reg[j] <= side_prev;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/line_sensor_centroid_core.sv
// ----------------------------------------------------------------------------
// line_sensor_centroid_core
// Six-sensor line position: spread term, threshold test and weighted centroid.
// ----------------------------------------------------------------------------
// Pipeline: 5 front stages, 14 divider stages and 1 output register between
//          request accept and result valid.
// Throughput: one request per cycle; stalls hold per stage, bubbles collapse.
// Reset: all valid bits cleared, the threshold register returns to 102.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_centroid_core #(
    parameter int SAMPLE_BITS = lsc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [lsc_pkg::THR_W-1:0]         cfg_write_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [SAMPLE_BITS-1:0]            sample_zero,
    input  wire logic [SAMPLE_BITS-1:0]            sample_one,
    input  wire logic [SAMPLE_BITS-1:0]            sample_two,
    input  wire logic [SAMPLE_BITS-1:0]            sample_three,
    input  wire logic [SAMPLE_BITS-1:0]            sample_four,
    input  wire logic [SAMPLE_BITS-1:0]            sample_five,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   line_found,
    output logic signed [lsc_pkg::POS_W-1:0]       position,
    output logic [lsc_pkg::SPREAD_W-1:0]           spread
);
    import lsc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SUM_W = SB + 3;
    localparam int SQ_W  = 2 * SB;
    localparam int SSQ_W = 2 * SB + 3;
    localparam int SPW   = 2 * SUM_W;
    localparam int WW    = SB + 5;
    localparam int PW    = SB + 17;
    localparam int ND    = SB + 16;
    localparam int CMP_W = SPW + LIMIT_W;
    localparam int NSTG  = 5;

    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET =
        THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(30 * THR_SQ_RESET);

    // threshold and derived limit
    logic [THR_W-1:0]    thr_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            thr_sq_reg <= THR_SQ_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thr_reg <= cfg_write_data;
            end
            thr_sq_reg <= THR_SQ_W'(thr_reg) * THR_SQ_W'(thr_reg);
            limit_reg  <= (LIMIT_W'(thr_sq_reg) << 5) - (LIMIT_W'(thr_sq_reg) << 1);
        end
    end

    // front pipeline handshake
    logic [NSTG-1:0] pv_reg;
    logic [NSTG:0]   rdy;
    logic            div_in_ready;

    assign rdy[NSTG] = div_in_ready;
    assign in_ready  = rdy[0];

    for (genvar i = 0; i < NSTG; i++) begin : g_rdy
        assign rdy[i] = ~pv_reg[i] | rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                pv_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    pv_reg[i] <= pv_reg[i-1];
                end
            end
        end
    end

    // stage 1: inversion
    logic [SB-1:0] raw [6];
    logic [SB-1:0] s_reg [6];

    assign raw[0] = sample_zero;
    assign raw[1] = sample_one;
    assign raw[2] = sample_two;
    assign raw[3] = sample_three;
    assign raw[4] = sample_four;
    assign raw[5] = sample_five;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 6; i++)
            begin
                s_reg[i] <= ~raw[i];
            end
        end
    end

    // stage 2: squares, sum, weighted sum
    logic [SQ_W-1:0]        sq_next [6];
    logic [SQ_W-1:0]        sq_reg  [6];
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       sum2_reg;
    logic signed [WW-1:0]   sx [6];
    logic signed [WW-1:0]   d50;
    logic signed [WW-1:0]   d41;
    logic signed [WW-1:0]   d32;
    logic signed [WW-1:0]   w_next;
    logic signed [WW-1:0]   w2_reg;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            sq_next[i] = SQ_W'(s_reg[i]) * SQ_W'(s_reg[i]);
            sum_next   = sum_next + SUM_W'(s_reg[i]);
            sx[i]      = signed'(WW'(s_reg[i]));
        end
        d50    = sx[5] - sx[0];
        d41    = sx[4] - sx[1];
        d32    = sx[3] - sx[2];
        w_next = (d50 <<< 2) + d50 + (d41 <<< 1) + d41 + d32;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sq_reg   <= sq_next;
            sum2_reg <= sum_next;
            w2_reg   <= w_next;
        end
    end

    // stage 3: sum of squares, squared sum, scaled weighted sum
    logic [SSQ_W-1:0]     ssq_next;
    logic [SSQ_W-1:0]     ssq3_reg;
    logic [SPW-1:0]       sqsum3_reg;
    logic [SUM_W-1:0]     sum3_reg;
    logic signed [PW-1:0] wx;
    logic signed [PW-1:0] prod3_reg;

    always_comb
    begin
        ssq_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            ssq_next = ssq_next + SSQ_W'(sq_reg[i]);
        end
        wx = PW'(w2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            ssq3_reg   <= ssq_next;
            sqsum3_reg <= SPW'(sum2_reg) * SPW'(sum2_reg);
            sum3_reg   <= sum2_reg;
            prod3_reg  <= (wx <<< 11) + (wx <<< 7);   // x 2176
        end
    end

    // stage 4: spread term
    logic [SPW-1:0]       spread4_reg;
    logic [SUM_W-1:0]     sum4_reg;
    logic signed [PW-1:0] prod4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            spread4_reg <= (SPW'(ssq3_reg) << 2) + (SPW'(ssq3_reg) << 1) - sqsum3_reg;
            sum4_reg    <= sum3_reg;
            prod4_reg   <= prod3_reg;
        end
    end

    // stage 5: threshold test, sign and magnitude for the divider
    logic [CMP_W-1:0]     spread_ext;
    logic [PW-1:0]        mag_full;
    lsc_side_t            side_next;
    lsc_side_t            side5_reg;
    logic [ND-1:0]        mag5_reg;
    logic [SUM_W-1:0]     sum5_reg;

    always_comb
    begin
        spread_ext       = CMP_W'(spread4_reg);
        side_next.found  = spread_ext > CMP_W'(limit_reg);
        side_next.neg    = prod4_reg[PW-1];
        side_next.spread = spread_ext[SPREAD_W-1:0];
        mag_full         = prod4_reg[PW-1] ? PW'(-prod4_reg) : PW'(prod4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            side5_reg <= side_next;
            mag5_reg  <= mag_full[ND-1:0];
            sum5_reg  <= sum4_reg;
        end
    end

    // divider
    logic             div_out_valid;
    logic             div_out_ready;
    logic [QBITS-1:0] div_quot;
    lsc_side_t        div_side;

    lsc_div #(
        .DIVIDEND_W (ND),
        .DIVISOR_W  (SUM_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pv_reg[NSTG-1]),
        .in_ready    (div_in_ready),
        .in_dividend (mag5_reg),
        .in_divisor  (sum5_reg),
        .in_side     (side5_reg),
        .out_valid   (div_out_valid),
        .out_ready   (div_out_ready),
        .out_quot    (div_quot),
        .out_side    (div_side)
    );

    // output register
    logic                    out_valid_reg;
    logic                    line_found_reg;
    logic signed [POS_W-1:0] position_reg;
    logic [SPREAD_W-1:0]     spread_reg;
    logic signed [POS_W-1:0] qx;
    logic signed [POS_W-1:0] position_next;

    assign div_out_ready = ~out_valid_reg | out_ready;

    always_comb
    begin
        qx = signed'(POS_W'(div_quot));
        if (!div_side.found)
        begin
            position_next = '0;
        end
        else if (div_side.neg)
        begin
            position_next = -qx;
        end
        else
        begin
            position_next = qx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready)
        begin
            line_found_reg <= div_side.found;
            position_reg   <= position_next;
            spread_reg     <= div_side.spread;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_found = line_found_reg;
    assign position   = position_reg;
    assign spread     = spread_reg;

endmodule

`default_nettype wire
